FILE: rtl/star_wildcard_name_matcher_macros.svh
// Assertion macros used by swnm_checker.
`ifndef STAR_WILDCARD_NAME_MATCHER_MACROS_SVH
`define STAR_WILDCARD_NAME_MATCHER_MACROS_SVH

// Same-cycle implication.
`define SWNM_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SWNM_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/swnm_pkg.sv
package swnm_pkg;

  localparam int MAX_PATTERN_BYTES = 16;
  localparam int NUM_POS           = MAX_PATTERN_BYTES + 1;
  localparam int POS_W             = $clog2(NUM_POS);
  localparam int LEN_W             = 5;
  localparam int CFG_DATA_W        = 64;
  localparam int CFG_IDX_W         = 2;

  localparam logic [7:0] STAR_BYTE = 8'h2A;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 2'd2;

  // Signals handed from one cell to the next.
  typedef struct packed {
    logic adv;    // position advanced by the current byte
    logic carry;  // closed position that sits on a star
    logic start;  // position belongs to the start set
  } link_t;

  // Length clamped to the number of cells.
  function automatic logic [POS_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    logic [POS_W-1:0] res;
    if (len > LEN_W'(MAX_PATTERN_BYTES)) res = POS_W'(MAX_PATTERN_BYTES);
    else res = POS_W'(len);
    return res;
  endfunction

endpackage

FILE: rtl/swnm_in_if.sv
interface swnm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_byte;
  logic       last_byte;

  modport source (output valid, output name_byte, output last_byte, input ready);
  modport sink   (input valid, input name_byte, input last_byte, output ready);
endinterface

FILE: rtl/swnm_out_if.sv
interface swnm_out_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, output matched, input ready);
  modport sink   (input valid, input matched, output ready);
endinterface

FILE: rtl/swnm_cell.sv
// One pattern position: holds its active bit and tests one pattern byte.
module swnm_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          pat_byte,
  input  logic                en,
  input  logic [7:0]          name_byte,
  input  logic                step,
  input  logic                restart,
  input  swnm_pkg::link_t     lnk_in,
  output swnm_pkg::link_t     lnk_out,
  output logic                closed
);
  import swnm_pkg::*;

  logic act;
  logic act_eff;
  logic hit;
  logic is_star;

  assign act_eff = restart ? lnk_in.start : act;
  assign hit     = en & act_eff;
  assign is_star = (pat_byte == STAR_BYTE);

  // Star keeps its own position; a star or equal byte moves one on.
  assign closed          = (hit & is_star) | lnk_in.adv | lnk_in.carry;
  assign lnk_out.adv     = hit & (is_star | (pat_byte == name_byte));
  assign lnk_out.carry   = closed & is_star & en;
  assign lnk_out.start   = lnk_in.start & is_star & en;

  always_ff @(posedge clk) begin
    if (rst) begin
      act <= 1'b0;
    end else if (step) begin
      act <= closed;
    end
  end

endmodule

FILE: rtl/star_wildcard_name_matcher.sv
// Channel    | Dir | Payload               | Transfer
// name_in    | in  | name_byte, last_byte  | valid & ready
// result_out | out | matched               | valid & ready
// config     | in  | cfg_index, cfg_data   | cfg_wr_en
//
// One name byte per cycle while name_in is not stalled; all 16 cells update together, star closure
// ripples through the cell chain in the same cycle.
// matched appears the cycle after the last byte is taken, held in an output register.
// name_in stalls only while a result waits in that register and result_out is not ready.
// Reset (synchronous, rst high) clears the pattern and rearms the start set;
// any config write to a listed register also rearms it.
module star_wildcard_name_matcher (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [swnm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swnm_pkg::CFG_DATA_W-1:0]     cfg_data,
  swnm_in_if.sink                             name_in,
  swnm_out_if.source                          result_out
);
  import swnm_pkg::*;

  logic [CFG_DATA_W-1:0]          pat_lo;
  logic [CFG_DATA_W-1:0]          pat_hi;
  logic [LEN_W-1:0]               pat_len;
  logic [2*CFG_DATA_W-1:0]        pat_all;
  logic [POS_W-1:0]               len_eff;
  logic                           restart;
  logic                           fire;
  logic                           out_valid;
  logic                           matched;
  logic                           cfg_hit;
  link_t                          lnk [0:MAX_PATTERN_BYTES];
  logic [NUM_POS-1:0]             closed;

  assign pat_all = {pat_hi, pat_lo};
  assign len_eff = eff_len(pat_len);

  assign name_in.ready     = !out_valid || result_out.ready;
  assign fire              = name_in.valid && name_in.ready;
  assign result_out.valid   = out_valid;
  assign result_out.matched = matched;

  assign lnk[0] = '{adv: 1'b0, carry: 1'b0, start: 1'b1};

  genvar p;
  generate
    for (p = 0; p < MAX_PATTERN_BYTES; p++) begin : g_cell
      swnm_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .pat_byte  (pat_all[8*p +: 8]),
        .en        (POS_W'(p) < len_eff),
        .name_byte (name_in.name_byte),
        .step      (fire),
        .restart   (restart),
        .lnk_in    (lnk[p]),
        .lnk_out   (lnk[p+1]),
        .closed    (closed[p])
      );
    end
  endgenerate

  // The position past the last cell has no cell of its own.
  assign closed[MAX_PATTERN_BYTES] = lnk[MAX_PATTERN_BYTES].adv |
                                     lnk[MAX_PATTERN_BYTES].carry;

  always_comb begin
    cfg_hit = 1'b0;
    unique case (cfg_index)
      CFG_PATTERN_LOW, CFG_PATTERN_HIGH, CFG_PATTERN_LEN: cfg_hit = cfg_wr_en;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_lo  <= '0;
      pat_hi  <= '0;
      pat_len <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_PATTERN_LOW:  pat_lo  <= cfg_data;
        CFG_PATTERN_HIGH: pat_hi  <= cfg_data;
        CFG_PATTERN_LEN:  pat_len <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Cells read the start set instead of their bit while restart is up.
  always_ff @(posedge clk) begin
    if (rst) begin
      restart <= 1'b1;
    end else if (cfg_hit) begin
      restart <= 1'b1;
    end else if (fire) begin
      restart <= name_in.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && name_in.last_byte) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && name_in.last_byte) begin
      matched <= closed[len_eff];
    end
  end

endmodule

FILE: rtl/swnm_checker.sv
`include "star_wildcard_name_matcher_macros.svh"

module swnm_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready
);
  logic in_xfer;

  assign in_xfer = in_valid && in_ready;

  `SWNM_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `SWNM_ASSERT_NXT(a_last_gives_result, clk, rst, in_xfer && in_last, out_valid, "no result after last byte")
  `SWNM_ASSERT_IMP(a_no_overrun, clk, rst, in_xfer && in_last, !out_valid || out_ready, "last byte taken over a pending result")
  `SWNM_ASSERT_IMP(a_result_cause, clk, rst, out_valid && !$past(out_valid), $past(in_xfer && in_last), "result without a last byte")

endmodule

bind star_wildcard_name_matcher swnm_checker u_swnm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (name_in.valid),
  .in_ready  (name_in.ready),
  .in_last   (name_in.last_byte),
  .out_valid (result_out.valid),
  .out_ready (result_out.ready)
);
